/* design/linear_block_code_codec_assert.svh */
// ----------------------------------------------------------------------------
// linear block code codec assertion macros
// shared concurrent assertion forms for the codec
// ----------------------------------------------------------------------------
`ifndef LINEAR_BLOCK_CODE_CODEC_ASSERT_SVH
`define LINEAR_BLOCK_CODE_CODEC_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// constants, types and the parity function of the linear block code codec
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int DATA_BITS  = 5;
	localparam int CODE_BITS  = 9;
	localparam int CHECK_BITS = CODE_BITS - DATA_BITS;
	localparam int GEN_W      = CHECK_BITS * DATA_BITS;
	localparam int CHK_W      = CHECK_BITS * CODE_BITS;
	localparam int POS_W      = 4;
	localparam int CNT_W      = 16;
	localparam int IDX_W      = 2;
	localparam int CFG_W      = CHK_W;

	localparam logic [IDX_W-1:0] REG_GENERATOR = 2'd0;
	localparam logic [IDX_W-1:0] REG_CHECK     = 2'd1;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAN     = 2'd0,
		ST_CORRECTED = 2'd1,
		ST_NO_MATCH  = 2'd2,
		ST_NOT_CODE  = 2'd3
	} status_t;

	// result of the column search
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} loc_t;

	// parity bits of a data value, parity row 0 in the top parity bit
	function automatic logic [CHECK_BITS-1:0] parity_f(
		input logic [DATA_BITS-1:0] d,
		input logic [GEN_W-1:0]     g
	);
		logic [CHECK_BITS-1:0] p;
		p = '0;
		for (int r = 0; r < CHECK_BITS; r++) begin
			for (int c = 0; c < DATA_BITS; c++) begin
				p[CHECK_BITS-1-r] = p[CHECK_BITS-1-r] ^ (d[DATA_BITS-1-c] & g[r*DATA_BITS+c]);
			end
		end
		return p;
	endfunction

endpackage

/* design/linear_block_code_codec.sv */
// throughput: one beat per cycle, stages s1..s4 advance together unless the
//   output beat is held by out_stall
// reset: arst_n clears valid bits, the error word counter and both matrices
// ----------------------------------------------------------------------------
// linear_block_code_codec
// systematic linear block encoder and single-error-correcting decoder
// ----------------------------------------------------------------------------
`include "linear_block_code_codec_assert.svh"

module linear_block_code_codec (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [lbc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [lbc_pkg::CFG_W-1:0]           cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [lbc_pkg::DATA_BITS-1:0]       data_value,
	input  logic [lbc_pkg::CODE_BITS-1:0]       received_word,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lbc_pkg::CODE_BITS-1:0]       codeword,
	output logic [lbc_pkg::DATA_BITS-1:0]       decoded_value,
	output logic [1:0]                          status,
	output logic [lbc_pkg::POS_W-1:0]           error_position,
	output logic [lbc_pkg::CNT_W-1:0]           errored_words
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [lbc_pkg::GEN_W-1:0] gen_q;
	logic [lbc_pkg::CHK_W-1:0] chk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
			chk_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lbc_pkg::REG_GENERATOR: gen_q <= cfg_data[lbc_pkg::GEN_W-1:0];
				lbc_pkg::REG_CHECK:     chk_q <= cfg_data[lbc_pkg::CHK_W-1:0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline control: all stages move together, the output register is
	// freed as soon as the downstream side takes its beat
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv;

	assign adv      = !valid_s4 || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// ------------------------------------------------------------------
	// s1: input capture
	// ------------------------------------------------------------------
	logic                          op_s1;
	logic [lbc_pkg::DATA_BITS-1:0] data_s1;
	logic [lbc_pkg::CODE_BITS-1:0] word_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= op;
			data_s1 <= data_value;
			word_s1 <= received_word;
		end
	end

	// ------------------------------------------------------------------
	// s2: syndrome of the received word, or the encoded word
	// ------------------------------------------------------------------
	logic [lbc_pkg::CHECK_BITS-1:0] synd_c;
	logic [lbc_pkg::CODE_BITS-1:0]  enc_word_c;

	// word position l sits at bit CODE_BITS-1-l
	always_comb begin
		synd_c = '0;
		for (int j = 0; j < lbc_pkg::CHECK_BITS; j++) begin
			for (int l = 0; l < lbc_pkg::CODE_BITS; l++) begin
				synd_c[j] = synd_c[j] ^
					(word_s1[lbc_pkg::CODE_BITS-1-l] & chk_q[j*lbc_pkg::CODE_BITS+l]);
			end
		end
	end

	assign enc_word_c = {data_s1, lbc_pkg::parity_f(data_s1, gen_q)};

	logic                           op_s2;
	logic [lbc_pkg::CODE_BITS-1:0]  word_s2;
	logic [lbc_pkg::CHECK_BITS-1:0] synd_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			// encode beats carry the finished codeword from here on
			word_s2 <= (op_s1 == lbc_pkg::OP_ENCODE) ? enc_word_c : word_s1;
			synd_s2 <= synd_c;
		end
	end

	// ------------------------------------------------------------------
	// s3: column search, bit flip, error counter
	// ------------------------------------------------------------------
	lbc_pkg::loc_t loc_c;

	lbc_locator u_locator (
		.syndrome   (synd_s2),
		.check_bits (chk_q),
		.loc        (loc_c)
	);

	logic                          dec_s2;
	logic                          dirty_s2;
	logic [lbc_pkg::CODE_BITS-1:0] flip_c;
	logic [lbc_pkg::CNT_W-1:0]     count_q;
	logic [lbc_pkg::CNT_W-1:0]     count_next_c;
	lbc_pkg::status_t              pre_status_c;
	logic [lbc_pkg::POS_W-1:0]     pos_c;

	assign dec_s2   = (op_s2 == lbc_pkg::OP_DECODE);
	assign dirty_s2 = dec_s2 && (synd_s2 != '0);

	// one-hot flip mask for the located position
	always_comb begin
		flip_c = '0;
		for (int p = 0; p < lbc_pkg::CODE_BITS; p++) begin
			flip_c[lbc_pkg::CODE_BITS-1-p] = dirty_s2 && loc_c.found &&
				(loc_c.pos == lbc_pkg::POS_W'(p));
		end
	end

	always_comb begin
		pre_status_c = lbc_pkg::ST_CLEAN;
		pos_c        = '0;
		if (dirty_s2) begin
			if (loc_c.found) begin
				pre_status_c = lbc_pkg::ST_CORRECTED;
				pos_c        = loc_c.pos;
			end else begin
				pre_status_c = lbc_pkg::ST_NO_MATCH;
			end
		end
	end

	// saturating count of decoded beats with a nonzero syndrome
	assign count_next_c = (dirty_s2 && (count_q != '1)) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv && valid_s2) begin
			count_q <= count_next_c;
		end
	end

	logic                          dec_s3;
	logic [lbc_pkg::CODE_BITS-1:0] word_s3;
	lbc_pkg::status_t              status_s3;
	logic [lbc_pkg::POS_W-1:0]     pos_s3;
	logic [lbc_pkg::CNT_W-1:0]     count_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s3    <= dec_s2;
			word_s3   <= word_s2 ^ flip_c;
			status_s3 <= pre_status_c;
			pos_s3    <= pos_c;
			count_s3  <= count_next_c;
		end
	end

	// ------------------------------------------------------------------
	// s4: re-encode check of the decoded word, output register
	// ------------------------------------------------------------------
	logic [lbc_pkg::DATA_BITS-1:0] data_s3;
	logic                          mismatch_c;
	lbc_pkg::status_t              final_status_c;

	assign data_s3    = word_s3[lbc_pkg::CODE_BITS-1 -: lbc_pkg::DATA_BITS];
	assign mismatch_c = lbc_pkg::parity_f(data_s3, gen_q) !=
		word_s3[lbc_pkg::CHECK_BITS-1:0];

	// a word whose syndrome matched no column skips the parity check
	assign final_status_c = (dec_s3 && (status_s3 != lbc_pkg::ST_NO_MATCH) && mismatch_c)
		? lbc_pkg::ST_NOT_CODE : status_s3;

	logic [lbc_pkg::CODE_BITS-1:0] word_s4;
	logic [lbc_pkg::DATA_BITS-1:0] data_s4;
	lbc_pkg::status_t              status_s4;
	logic [lbc_pkg::POS_W-1:0]     pos_s4;
	logic [lbc_pkg::CNT_W-1:0]     count_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s4   <= word_s3;
			data_s4   <= data_s3;
			status_s4 <= final_status_c;
			pos_s4    <= pos_s3;
			count_s4  <= count_s3;
		end
	end

	assign out_valid      = valid_s4;
	assign codeword       = word_s4;
	assign decoded_value  = data_s4;
	assign status         = status_s4;
	assign error_position = pos_s4;
	assign errored_words  = count_s4;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// input is only held back while a finished beat waits downstream
	`LBC_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, valid_s4 && out_stall, "in_stall without a held output beat")
	// a clean beat reports no flipped position
	`LBC_ASSERT_NOW(a_clean_no_pos, clk, arst_n, out_valid && (status_s4 == lbc_pkg::ST_CLEAN), error_position == '0, "clean beat with a flip position")
	// a corrected beat is a true codeword under the live generator
	`LBC_ASSERT_NOW(a_corrected_ok, clk, arst_n, out_valid && (status_s4 == lbc_pkg::ST_CORRECTED), lbc_pkg::parity_f(decoded_value, gen_q) == codeword[lbc_pkg::CHECK_BITS-1:0], "corrected beat fails parity")
	// the error counter never moves backwards
	`LBC_ASSERT_NEXT(a_count_mono, clk, arst_n, 1'b1, count_q >= $past(count_q), "error counter decreased")

endmodule

/* design/lbc_locator.sv */
// ----------------------------------------------------------------------------
// lbc_locator
// finds the check-matrix column equal to a syndrome, highest position wins
// ----------------------------------------------------------------------------
module lbc_locator (
	input  logic [lbc_pkg::CHECK_BITS-1:0] syndrome,
	input  logic [lbc_pkg::CHK_W-1:0]      check_bits,
	output lbc_pkg::loc_t                  loc
);

	logic [lbc_pkg::CHECK_BITS-1:0] column [lbc_pkg::CODE_BITS];

	// gather each column, row j at bit j
	always_comb begin
		for (int p = 0; p < lbc_pkg::CODE_BITS; p++) begin
			for (int j = 0; j < lbc_pkg::CHECK_BITS; j++) begin
				column[p][j] = check_bits[j*lbc_pkg::CODE_BITS+p];
			end
		end
	end

	// later matches overwrite earlier ones
	always_comb begin
		loc = '0;
		for (int p = 0; p < lbc_pkg::CODE_BITS; p++) begin
			if (column[p] == syndrome) begin
				loc.found = 1'b1;
				loc.pos   = lbc_pkg::POS_W'(p);
			end
		end
	end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the (9,5) linear block code codec: beats are driven
// through the valid/stall channels, each accepted input beat is run through a
// bench-side model of the encoder and single-error-correcting decoder, and every
// output beat is compared field by field against the oldest pending prediction
// ----------------------------------------------------------------------------

// one output beat of the codec
typedef struct packed {
	logic [lbc_pkg::CODE_BITS-1:0] codeword;
	logic [lbc_pkg::DATA_BITS-1:0] decoded_value;
	lbc_pkg::status_t              status;
	logic [lbc_pkg::POS_W-1:0]     error_position;
	logic [lbc_pkg::CNT_W-1:0]     errored_words;
} codec_result_t;

class codec_scoreboard;
	logic [lbc_pkg::GEN_W-1:0] gen_reg;
	logic [lbc_pkg::CHK_W-1:0] chk_reg;
	logic [lbc_pkg::CNT_W-1:0] bad_word_count;
	codec_result_t             pending_results[$];
	int                        fail_count;
	int                        beats_seen;

	function new();
		gen_reg        = '0;
		chk_reg        = '0;
		bad_word_count = '0;
		fail_count     = 0;
		beats_seen     = 0;
	endfunction

	// indexes past the register list are dropped
	function void write_register(logic [lbc_pkg::IDX_W-1:0] idx,
			logic [lbc_pkg::CFG_W-1:0] value);
		case (idx)
			lbc_pkg::REG_GENERATOR: gen_reg = value[lbc_pkg::GEN_W-1:0];
			lbc_pkg::REG_CHECK:     chk_reg = value[lbc_pkg::CHK_W-1:0];
			default: ;
		endcase
	endfunction

	// data bits followed by the parity bits of the current generator
	function logic [lbc_pkg::CODE_BITS-1:0] encode_data(logic [lbc_pkg::DATA_BITS-1:0] d);
		logic [lbc_pkg::CHECK_BITS-1:0] par;
		par = '0;
		for (int r = 0; r < lbc_pkg::CHECK_BITS; r++)
			for (int c = 0; c < lbc_pkg::DATA_BITS; c++)
				par[lbc_pkg::CHECK_BITS-1-r] ^= d[lbc_pkg::DATA_BITS-1-c]
					& gen_reg[r*lbc_pkg::DATA_BITS+c];
		return {d, par};
	endfunction

	function void predict_beat(logic o, logic [lbc_pkg::DATA_BITS-1:0] d,
			logic [lbc_pkg::CODE_BITS-1:0] w);
		codec_result_t                  want;
		logic [lbc_pkg::CHECK_BITS-1:0] synd;
		logic [lbc_pkg::CHECK_BITS-1:0] col;
		logic                           hit;
		int                             flip_at;
		want.status         = lbc_pkg::ST_CLEAN;
		want.error_position = '0;
		if (o == lbc_pkg::OP_ENCODE) begin
			want.codeword = encode_data(d);
		end else begin
			want.codeword = w;
			synd = '0;
			for (int j = 0; j < lbc_pkg::CHECK_BITS; j++)
				for (int l = 0; l < lbc_pkg::CODE_BITS; l++)
					synd[j] ^= w[lbc_pkg::CODE_BITS-1-l] & chk_reg[j*lbc_pkg::CODE_BITS+l];
			if (synd != '0) begin
				hit     = 1'b0;
				flip_at = 0;
				// scan every column, the highest position that matches wins
				for (int p = 0; p < lbc_pkg::CODE_BITS; p++) begin
					for (int j = 0; j < lbc_pkg::CHECK_BITS; j++)
						col[j] = chk_reg[j*lbc_pkg::CODE_BITS+p];
					if (col == synd) begin
						hit     = 1'b1;
						flip_at = p;
					end
				end
				if (bad_word_count != '1)
					bad_word_count++;
				if (hit) begin
					want.codeword[lbc_pkg::CODE_BITS-1-flip_at] ^= 1'b1;
					want.error_position = lbc_pkg::POS_W'(flip_at);
					want.status         = lbc_pkg::ST_CORRECTED;
				end else begin
					want.status = lbc_pkg::ST_NO_MATCH;
				end
			end
			if (want.status != lbc_pkg::ST_NO_MATCH && encode_data(
					want.codeword[lbc_pkg::CODE_BITS-1 -: lbc_pkg::DATA_BITS]) != want.codeword)
				want.status = lbc_pkg::ST_NOT_CODE;
		end
		want.decoded_value = want.codeword[lbc_pkg::CODE_BITS-1 -: lbc_pkg::DATA_BITS];
		want.errored_words = bad_word_count;
		pending_results.insert(pending_results.size(), want);
	endfunction

	task report_mismatch(string msg);
		$display("[%0t] output beat %0d: %s", $realtime, beats_seen, msg);
		fail_count++;
	endtask

	task check_beat(codec_result_t got);
		codec_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("output beat with nothing pending");
		end else begin
			want = pending_results.pop_front();
			if (got.codeword !== want.codeword)
				report_mismatch($sformatf("codeword %h, predicted %h",
					got.codeword, want.codeword));
			if (got.decoded_value !== want.decoded_value)
				report_mismatch($sformatf("decoded_value %h, predicted %h",
					got.decoded_value, want.decoded_value));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, predicted %0d",
					got.status, want.status));
			if (got.error_position !== want.error_position)
				report_mismatch($sformatf("error_position %0d, predicted %0d",
					got.error_position, want.error_position));
			if (got.errored_words !== want.errored_words)
				report_mismatch($sformatf("errored_words %0d, predicted %0d",
					got.errored_words, want.errored_words));
		end
		beats_seen++;
	endtask
endclass

module tb_top;
	import lbc_pkg::*;

	// spare register indexes, writes there must be dropped
	localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int LATENCY      = 4;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_BEATS  = 80;
	localparam int HOLD_CYCLES  = 300;

	// check-matrix columns of the data positions, row j at bit j
	localparam logic [CHECK_BITS-1:0] HAMMING_COLS [DATA_BITS] = '{4'd3, 4'd5, 4'd6, 4'd7, 4'd9};
	// positions 0 and 4 share a column so the decoder must pick the later one
	localparam logic [CHECK_BITS-1:0] TWIN_COLS    [DATA_BITS] = '{4'd3, 4'd5, 4'd6, 4'd7, 4'd3};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  op;
	logic [DATA_BITS-1:0]  data_value;
	logic [CODE_BITS-1:0]  received_word;
	logic                  out_valid;
	logic                  out_stall;
	logic [CODE_BITS-1:0]  codeword;
	logic [DATA_BITS-1:0]  decoded_value;
	logic [1:0]            status;
	logic [POS_W-1:0]      error_position;
	logic [CNT_W-1:0]      errored_words;

	codec_scoreboard       sb;
	int                    cycle_count = 0;
	bit                    quiet = 1'b0;    // no gaps and no stalls while set
	bit                    hold_on = 1'b0;  // long receiver hold-off in progress

	linear_block_code_codec dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.data_value     (data_value),
		.received_word  (received_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.codeword       (codeword),
		.decoded_value  (decoded_value),
		.status         (status),
		.error_position (error_position),
		.errored_words  (errored_words)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run guard, far above the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("linear_block_code_codec: mismatch");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver stall pattern: runs of stall and of ready, overridden by a hold-off
	initial begin
		int  run_left;
		bit  stalled;
		run_left = 0;
		stalled  = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_on) begin
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stalled  = !quiet && ($urandom_range(0, 2) == 0);
					run_left = stalled ? gap_length() + 1 : $urandom_range(1, 10);
				end
				run_left--;
				out_stall <= stalled;
			end
		end
	end

	// take every output beat at the edge where it is accepted
	always @(posedge clk) begin
		codec_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.codeword       = codeword;
			got.decoded_value  = decoded_value;
			got.status         = status_t'(status);
			got.error_position = error_position;
			got.errored_words  = errored_words;
			sb.check_beat(got);
		end
	end

	// receiver holds off long enough for the pipeline to back up into in_stall
	task automatic hold_output();
		@(posedge clk);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
	endtask

	// called at a falling edge, returns at the falling edge after the write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.write_register(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// systematic code from its data columns, generator padded with junk high bits
	task automatic load_code(input logic [CHECK_BITS-1:0] cols [DATA_BITS]);
		logic [GEN_W-1:0] g;
		logic [CHK_W-1:0] h;
		g = '0;
		h = '0;
		for (int c = 0; c < DATA_BITS; c++)
			for (int r = 0; r < CHECK_BITS; r++) begin
				g[r*DATA_BITS+c] = cols[c][r];
				h[r*CODE_BITS+c] = cols[c][r];
			end
		for (int j = 0; j < CHECK_BITS; j++)
			h[j*CODE_BITS+DATA_BITS+j] = 1'b1;
		write_reg(REG_GENERATOR, {{(CFG_W-GEN_W){1'b1}}, g});
		write_reg(REG_CHECK, h);
	endtask

	// one input beat, entered and left at a falling edge; valid stays up
	// afterwards so back-to-back beats need no extra assignment
	task automatic send_beat(input logic o, input logic [DATA_BITS-1:0] d,
			input logic [CODE_BITS-1:0] w);
		int gap;
		gap = quiet ? 0 : gap_length();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		op            <= o;
		data_value    <= d;
		received_word <= w;
		do @(posedge clk); while (in_stall);
		sb.predict_beat(o, d, w);
		@(negedge clk);
	endtask

	// mostly codewords with random data and zero, one or two flipped bits,
	// the rest plain encodes and noise words
	task automatic send_random_beat();
		logic [DATA_BITS-1:0] d;
		logic [CODE_BITS-1:0] noise;
		logic [CODE_BITS-1:0] flip;
		int                   roll;
		d     = DATA_BITS'($urandom);
		noise = CODE_BITS'($urandom);
		flip  = CODE_BITS'(1) << $urandom_range(0, CODE_BITS - 1);
		roll  = $urandom_range(0, 99);
		if (roll < 30)
			send_beat(OP_ENCODE, d, noise);
		else if (roll < 60)
			send_beat(OP_DECODE, d, sb.encode_data(d) ^ flip);
		else if (roll < 75)
			send_beat(OP_DECODE, noise[DATA_BITS-1:0], sb.encode_data(d));
		else if (roll < 87)
			send_beat(OP_DECODE, d, sb.encode_data(d) ^ flip
				^ (CODE_BITS'(1) << $urandom_range(0, CODE_BITS - 1)));
		else
			send_beat(OP_DECODE, d, noise);
	endtask

	// wait for every pending beat, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [CODE_BITS-1:0] clean_word;

		sb = new();
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_GENERATOR;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		op            <= OP_ENCODE;
		data_value    <= '0;
		received_word <= '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// spare indexes first, the matrices must still read as zero
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '1);
		send_beat(OP_ENCODE, 5'd0, 9'h000);
		send_beat(OP_ENCODE, 5'd31, 9'h1FF);
		send_beat(OP_DECODE, 5'd31, 9'h000);
		// zero syndrome but parity bits set: not a codeword
		send_beat(OP_DECODE, 5'd0, 9'h1FF);
		drain();

		// proper single-error-correcting code
		load_code(HAMMING_COLS);
		send_beat(OP_ENCODE, 5'd0, 9'h000);
		send_beat(OP_ENCODE, 5'd31, 9'h000);
		send_beat(OP_ENCODE, 5'b10101, 9'h1FF);
		clean_word = sb.encode_data(5'b10110);
		send_beat(OP_DECODE, 5'd0, clean_word);
		// single errors at the first and last positions
		send_beat(OP_DECODE, 5'd31, sb.encode_data(5'b01101) ^ 9'h100);
		send_beat(OP_DECODE, 5'd0, sb.encode_data(5'b01101) ^ 9'h001);
		// double error that aliases onto another column
		send_beat(OP_DECODE, 5'd0, sb.encode_data(5'b11001) ^ 9'h180);
		// double error whose syndrome matches no column
		send_beat(OP_DECODE, 5'd0, sb.encode_data(5'b11001) ^ 9'h110);
		drain();

		// generator cleared under the same check matrix: clean and corrected
		// words both fail the parity recheck
		write_reg(REG_GENERATOR, '0);
		send_beat(OP_DECODE, 5'd0, clean_word);
		send_beat(OP_DECODE, 5'd0, clean_word ^ 9'h040);
		drain();

		// duplicated column, the later position takes the flip
		load_code(TWIN_COLS);
		send_beat(OP_DECODE, 5'd0, sb.encode_data(5'b00111) ^ 9'h100);
		drain();

		// all-ones matrices
		write_reg(REG_GENERATOR, '1);
		write_reg(REG_CHECK, '1);
		send_beat(OP_ENCODE, 5'd31, 9'h000);
		send_beat(OP_DECODE, 5'd0, 9'h1FF);
		send_beat(OP_DECODE, 5'd0, 9'h100);
		drain();

		// random phases, each under its own matrices
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					// back-to-back beats against a long receiver hold-off
					load_code(HAMMING_COLS);
					quiet = 1'b1;
					fork
						hold_output();
					join_none
				end
				1: begin
					quiet = 1'b0;
					load_code(TWIN_COLS);
				end
				2: begin
					write_reg(REG_GENERATOR, '1);
					write_reg(REG_CHECK, '1);
				end
				3: begin
					write_reg(REG_GENERATOR, CFG_W'({$urandom, $urandom}));
					write_reg(REG_CHECK, CFG_W'({$urandom, $urandom}));
					write_reg(REG_SPARE_2, CFG_W'({$urandom, $urandom}));
				end
				default: begin
					load_code(HAMMING_COLS);
					write_reg(REG_SPARE_3, CFG_W'({$urandom, $urandom}));
				end
			endcase
			repeat (PHASE_BEATS) send_random_beat();
			drain();
		end

		if (sb.fail_count == 0)
			$display("linear_block_code_codec: match");
		else
			$display("linear_block_code_codec: mismatch");
		$finish;
	end

endmodule

/* linear_block_code_codec.f */
+incdir+design
design/lbc_pkg.sv
design/lbc_locator.sv
design/linear_block_code_codec.sv
bench/tb_top.sv
